FILE: rtl/sharpen_3x3_cross_stream_unit_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the sharpen unit
// checks compile away when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef SHARPEN_3X3_CROSS_STREAM_UNIT_ASSERT_SVH
`define SHARPEN_3X3_CROSS_STREAM_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked at every rising edge outside reset
`define SHP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every rising edge, reset included
`define SHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SHP_ASSERT(lbl, clk, rstn, prop, msg)

`define SHP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/sharp3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharp3_pkg
// shared types and constants of the cross sharpen unit
// ----------------------------------------------------------------------------
package sharp3_pkg;

  // queue between the read front and the arithmetic back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // clamped geometry as used by the datapath
  typedef struct packed {
    logic [2:0]  ch;    // channels per pixel, 1..4
    logic [12:0] rows;  // rows per frame, 3..4096
  } geom_t;

  // operands of one output byte
  typedef struct packed {
    logic [7:0] mid;
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] up;
    logic [7:0] below;
    logic       interior;
    logic       frame_end;
  } opnd_t;

endpackage

FILE: rtl/sharp3_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharp3_cfg
// apb register file, keeps raw values and the clamped line geometry
// ----------------------------------------------------------------------------
module sharp3_cfg
  import sharp3_pkg::*;
#(
  parameter int MAX_LINE_BYTES = 8192
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  output geom_t                                  geom_o,
  output logic [$clog2(MAX_LINE_BYTES+1)-1:0]    len_o,
  output logic [$clog2(MAX_LINE_BYTES+1)-1:0]    inner_o
);

  localparam int LW = $clog2(MAX_LINE_BYTES + 1);

  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_CHANS = 2'd2;

  // longest line that fits for each channel count
  localparam int MaxLen1 = MAX_LINE_BYTES;
  localparam int MaxLen2 = (MAX_LINE_BYTES / 2) * 2;
  localparam int MaxLen3 = (MAX_LINE_BYTES / 3) * 3;
  localparam int MaxLen4 = (MAX_LINE_BYTES / 4) * 4;

  function automatic logic [2:0] clamp_ch(logic [2:0] c);
    logic [2:0] r;
    r = c;
    if (c == 3'd0) r = 3'd1;
    else if (c > 3'd4) r = 3'd4;
    return r;
  endfunction

  function automatic logic [11:0] clamp_cols(logic [11:0] c);
    logic [11:0] r;
    r = c;
    if (c < 12'd3) r = 12'd3;
    else if (c > 12'd2048) r = 12'd2048;
    return r;
  endfunction

  function automatic logic [12:0] clamp_rows(logic [12:0] c);
    logic [12:0] r;
    r = c;
    if (c < 13'd3) r = 13'd3;
    else if (c > 13'd4096) r = 13'd4096;
    return r;
  endfunction

  // bytes per line from raw columns and raw channel count
  function automatic logic [LW-1:0] line_len(logic [11:0] cols_raw, logic [2:0] ch_raw);
    logic [2:0]  ch;
    logic [14:0] prod;
    int          cap;
    ch   = clamp_ch(ch_raw);
    prod = 15'(clamp_cols(cols_raw)) * 15'(ch);
    case (ch)
      3'd1:    cap = MaxLen1;
      3'd2:    cap = MaxLen2;
      3'd3:    cap = MaxLen3;
      default: cap = MaxLen4;
    endcase
    if (32'(prod) > 32'(MAX_LINE_BYTES)) return LW'(cap);
    return LW'(prod);
  endfunction

  logic [11:0]   cols_raw_q, cols_raw_d;
  logic [12:0]   rows_raw_q, rows_raw_d;
  logic [2:0]    ch_raw_q, ch_raw_d;
  logic [2:0]    ch_q;
  logic [12:0]   rows_q;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] inner_q;
  logic          wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cols_raw_d = cols_raw_q;
    rows_raw_d = rows_raw_q;
    ch_raw_d   = ch_raw_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_COLS:  cols_raw_d = pwdata[11:0];
        REG_ROWS:  rows_raw_d = pwdata[12:0];
        REG_CHANS: ch_raw_d   = pwdata[2:0];
        default: ;
      endcase
    end
    len_d = line_len(cols_raw_d, ch_raw_d);
  end

  // geometry follows the raw registers in the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_raw_q <= 12'd640;
      rows_raw_q <= 13'd480;
      ch_raw_q   <= 3'd3;
      ch_q       <= 3'd3;
      rows_q     <= 13'd480;
      len_q      <= line_len(12'd640, 3'd3);
      inner_q    <= line_len(12'd640, 3'd3) - LW'(3);
    end else begin
      cols_raw_q <= cols_raw_d;
      rows_raw_q <= rows_raw_d;
      ch_raw_q   <= ch_raw_d;
      ch_q       <= clamp_ch(ch_raw_d);
      rows_q     <= clamp_rows(rows_raw_d);
      len_q      <= len_d;
      inner_q    <= len_d - LW'(clamp_ch(ch_raw_d));
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COLS:  prdata = 32'(cols_raw_q);
      REG_ROWS:  prdata = 32'(rows_raw_q);
      REG_CHANS: prdata = 32'(ch_raw_q);
      default:   prdata = 32'd0;
    endcase
  end

  assign geom_o.ch   = ch_q;
  assign geom_o.rows = rows_q;
  assign len_o       = len_q;
  assign inner_o     = inner_q;

endmodule

FILE: rtl/sharp3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharp3_front
// accepts samples, tracks row and byte position, owns the two line stores
// ----------------------------------------------------------------------------
module sharp3_front
  import sharp3_pkg::*;
#(
  parameter int MAX_LINE_BYTES = 8192
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          sample_i,
  input  geom_t                               geom_i,
  input  logic [$clog2(MAX_LINE_BYTES+1)-1:0] len_i,
  input  logic [$clog2(MAX_LINE_BYTES+1)-1:0] inner_i,
  input  logic [QCW-1:0]                      q_count_i,
  output logic                                push_o,
  output opnd_t                               opnd_o
);

  localparam int AW = $clog2(MAX_LINE_BYTES);

  logic [12:0]   row_q, row_d;
  logic [AW-1:0] byte_q, byte_d;
  logic          sel_q, sel_d;

  logic          accept;
  logic          drain;
  logic          last_byte;
  logic          past_left;
  logic          before_right;
  logic          interior;
  logic [AW:0]   right_sum;
  logic [AW-1:0] addr_right;
  logic [AW-1:0] addr_left;
  logic          wr_a;
  logic          wr_b;

  // two copies per store: the first serves center and right, the second left
  logic [7:0] mem_a0 [MAX_LINE_BYTES];
  logic [7:0] mem_a1 [MAX_LINE_BYTES];
  logic [7:0] mem_b0 [MAX_LINE_BYTES];
  logic [7:0] mem_b1 [MAX_LINE_BYTES];

  logic [7:0] a_mid_q, a_right_q, a_left_q;
  logic [7:0] b_mid_q, b_right_q, b_left_q;

  logic       f1_valid_q;
  logic       f1_sel_q;
  logic [7:0] f1_sample_q;
  logic       f1_interior_q;
  logic       f1_frame_end_q;

  // room for this item and the one already in flight
  assign in_stall_o = ((QCW+1)'(q_count_i) + (QCW+1)'(f1_valid_q)) >= (QCW+1)'(QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    drain        = row_q >= geom_i.rows;
    last_byte    = ((AW+1)'(byte_q) + (AW+1)'(1)) >= (AW+1)'(len_i);
    past_left    = byte_q >= AW'(geom_i.ch);
    before_right = (AW+1)'(byte_q) < (AW+1)'(inner_i);
    interior     = (row_q >= 13'd2) && !drain && past_left && before_right;

    right_sum = (AW+1)'(byte_q) + (AW+1)'(geom_i.ch);
    if (right_sum >= (AW+1)'(MAX_LINE_BYTES)) begin
      addr_right = AW'(right_sum - (AW+1)'(MAX_LINE_BYTES));
    end else begin
      addr_right = AW'(right_sum);
    end
    addr_left = past_left ? (byte_q - AW'(geom_i.ch)) : byte_q;

    // the store not holding the row above takes the incoming row
    wr_a = accept && !drain && sel_q;
    wr_b = accept && !drain && !sel_q;

    row_d  = row_q;
    byte_d = byte_q;
    sel_d  = sel_q;
    if (accept) begin
      if (last_byte) begin
        byte_d = '0;
        sel_d  = !sel_q;
        row_d  = drain ? 13'd0 : (row_q + 13'd1);
      end else begin
        byte_d = byte_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) mem_a0[byte_q] <= sample_i;
    if (accept) begin
      a_mid_q   <= mem_a0[byte_q];
      a_right_q <= mem_a0[addr_right];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) mem_a1[byte_q] <= sample_i;
    if (accept) a_left_q <= mem_a1[addr_left];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) mem_b0[byte_q] <= sample_i;
    if (accept) begin
      b_mid_q   <= mem_b0[byte_q];
      b_right_q <= mem_b0[addr_right];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) mem_b1[byte_q] <= sample_i;
    if (accept) b_left_q <= mem_b1[addr_left];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      byte_q     <= '0;
      sel_q      <= 1'b0;
      f1_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      byte_q     <= byte_d;
      sel_q      <= sel_d;
      f1_valid_q <= accept && (row_q != 13'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_sel_q       <= sel_q;
      f1_sample_q    <= sample_i;
      f1_interior_q  <= interior;
      f1_frame_end_q <= drain && last_byte;
    end
  end

  always_comb begin
    opnd_o.mid       = f1_sel_q ? b_mid_q   : a_mid_q;
    opnd_o.left      = f1_sel_q ? b_left_q  : a_left_q;
    opnd_o.right     = f1_sel_q ? b_right_q : a_right_q;
    opnd_o.up        = f1_sel_q ? a_mid_q   : b_mid_q;
    opnd_o.below     = f1_sample_q;
    opnd_o.interior  = f1_interior_q;
    opnd_o.frame_end = f1_frame_end_q;
  end

  assign push_o = f1_valid_q;

endmodule

FILE: rtl/sharp3_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharp3_fifo
// short operand queue between front and back
// ----------------------------------------------------------------------------
module sharp3_fifo
  import sharp3_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  opnd_t          opnd_i,
  input  logic           pop_i,
  output opnd_t          opnd_o,
  output logic [QCW-1:0] count_o
);

  opnd_t          slot_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q;
  logic [QAW-1:0] rd_ptr_q;
  logic [QCW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= opnd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QAW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QAW'(1);
      count_q <= count_q + QCW'(push_i) - QCW'(pop_i);
    end
  end

  assign opnd_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

FILE: rtl/sharp3_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharp3_back
// cross filter arithmetic, saturation and the output register
// ----------------------------------------------------------------------------
module sharp3_back
  import sharp3_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  opnd_t      opnd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] sharpened_o,
  output logic       frame_end_o
);

  logic              out_valid_q;
  logic [7:0]        sharp_q, sharp_d;
  logic              frame_end_q;
  logic signed [11:0] acc;

  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  // 5*center minus the four neighbors, range -1020..1275
  always_comb begin
    acc = $signed({2'b00, opnd_i.mid, 2'b00}) + $signed(12'(opnd_i.mid))
        - $signed(12'(opnd_i.left)) - $signed(12'(opnd_i.right))
        - $signed(12'(opnd_i.up)) - $signed(12'(opnd_i.below));
    if (!opnd_i.interior) sharp_d = 8'd0;
    else if (acc < 12'sd0) sharp_d = 8'd0;
    else if (acc > 12'sd255) sharp_d = 8'd255;
    else sharp_d = acc[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sharp_q     <= sharp_d;
      frame_end_q <= opnd_i.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sharpened_o = sharp_q;
  assign frame_end_o = frame_end_q;

endmodule

FILE: rtl/sharpen_3x3_cross_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_cross_stream_unit
// streaming 3x3 cross sharpen over interleaved 8-bit channel bytes
//
// input channel: one channel byte per item in raster order, in_valid_i /
//   in_stall_o; after each frame the source sends one extra row of filler
//   items that flushes out the last row
// output channel: one item per input item except for items of row 0,
//   out_valid_o / out_stall_i; the output runs one row behind the input,
//   border rows and border pixels come out as zero, frame_end_o marks the
//   last byte of the frame
// path: front operand registers, operand queue, output register; throughput:
//   one item per cycle unless stalled; both line stores are read and written
//   in the acceptance cycle, a 4-entry operand queue decouples the arithmetic
// a stalled output fills the queue, then in_stall_o rises; nothing is lost
// reset: position counters clear, geometry returns to 640 x 480 x 3,
//   line store contents are not cleared (no result of rows 0 and 1 uses them)
// configuration: apb writes at 0x0 columns, 0x4 rows, 0x8 channels; write
//   only while no item is in flight
// ----------------------------------------------------------------------------
`include "sharpen_3x3_cross_stream_unit_assert.svh"

module sharpen_3x3_cross_stream_unit
  import sharp3_pkg::*;
#(
  parameter int MAX_LINE_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample stream in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  sample_i,
  // sharpened stream out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  sharpened_o,
  output logic        frame_end_o
);

  localparam int LW = $clog2(MAX_LINE_BYTES + 1);

  geom_t          geom;
  logic [LW-1:0]  line_len;
  logic [LW-1:0]  inner_end;
  logic           push;
  opnd_t          push_opnd;
  opnd_t          head_opnd;
  logic           pop;
  logic [QCW-1:0] q_count;
  logic           head_valid;

  // registers plus clamped geometry, updated in the write edge itself
  sharp3_cfg #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom_o  (geom),
    .len_o   (line_len),
    .inner_o (inner_end)
  );

  // front: position tracking, border classification, line stores
  sharp3_front #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .geom_i     (geom),
    .len_i      (line_len),
    .inner_i    (inner_end),
    .q_count_i  (q_count),
    .push_o     (push),
    .opnd_o     (push_opnd)
  );

  // operand queue; the front never pushes into a full queue
  sharp3_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .opnd_i  (push_opnd),
    .pop_i   (pop),
    .opnd_o  (head_opnd),
    .count_o (q_count)
  );

  assign head_valid = q_count != '0;

  // back: filter arithmetic and output register
  sharp3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .opnd_i       (head_opnd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sharpened_o  (sharpened_o),
    .frame_end_o  (frame_end_o)
  );

  // queued plus in-flight operands never exceed the queue depth
  `SHP_ASSERT(a_queue_bound, clk_i, rst_ni,
    (((QCW+1)'(q_count) + (QCW+1)'(push)) <= (QCW+1)'(QDEPTH)),
    "operand queue overflow")

  // input stalls only with a backlog in the queue
  `SHP_ASSERT(a_stall_backlog, clk_i, rst_ni, in_stall_o |-> (q_count != '0),
    "input stalled with empty queue")

  // the frame end byte sits in the bottom border row
  `SHP_ASSERT(a_frame_end_zero, clk_i, rst_ni,
    (out_valid_o && frame_end_o) |-> (sharpened_o == 8'd0),
    "frame end byte is not zero")

endmodule

FILE: tb/sv/sharpen_3x3_cross_stream_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_cross_stream_unit_tb
// self-checking bench for the streaming 3x3 cross sharpen unit: a short
// table of hand-worked frames, then whole frames of random bytes over many
// frame geometries, checked byte by byte against a local line-store model
// ----------------------------------------------------------------------------
module sharpen_3x3_cross_stream_unit_tb;

  localparam int LINE_BYTES    = 8192;
  localparam int CYCLE_LIMIT   = 50000;
  localparam int SETTLE_CYCLES = 12;     // margin for the pipeline tail
  localparam int RANDOM_ITEMS  = 700;
  localparam int IDLE_PCT      = 29;
  localparam int HOLD_CYCLES   = 300;
  localparam int DIRECTED_ROWS = 24;

  // apb register addresses
  localparam logic [3:0] REG_COLUMNS  = 4'h0;
  localparam logic [3:0] REG_ROWS     = 4'h4;
  localparam logic [3:0] REG_CHANNELS = 4'h8;

  typedef struct packed {
    logic [7:0] sharpened;
    logic       frame_end;
  } sharp_result_t;

  // one row of the directed table: input byte and the result it must give
  typedef struct packed {
    logic [7:0] sample;
    logic       emits;
    logic [7:0] sharpened;
    logic       frame_end;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  sample_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  sharpened_o;
  logic        frame_end_o;

  // model state: two line stores, which one holds the row above, position
  bit [7:0]    line_a [LINE_BYTES];
  bit [7:0]    line_b [LINE_BYTES];
  bit          line_sel  = 1'b0;
  int unsigned pos_row   = 0;
  int unsigned pos_byte  = 0;
  logic [11:0] cfg_cols  = 12'd640;
  logic [12:0] cfg_rows  = 13'd480;
  logic [2:0]  cfg_chans = 3'd3;

  sharp_result_t pending_bytes[$];
  int failures      = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int frames_sent   = 0;
  int geometries    = 0;
  int unsigned cycle_count = 0;

  // two hand-worked 3x3 single-channel frames plus their drain rows:
  // the first saturates high at the centre, the second saturates low,
  // drain-row bytes must be ignored
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    // frame A, row 0: no output
    '{8'd17,  1'b0, 8'd0,   1'b0}, '{8'd0,   1'b0, 8'd0, 1'b0},
    '{8'd99,  1'b0, 8'd0,   1'b0},
    // row 1: emits border row 0
    '{8'd0,   1'b1, 8'd0,   1'b0}, '{8'd255, 1'b1, 8'd0, 1'b0},
    '{8'd0,   1'b1, 8'd0,   1'b0},
    // row 2: emits row 1, centre 5*255 clips to 255
    '{8'd200, 1'b1, 8'd0,   1'b0}, '{8'd0,   1'b1, 8'd255, 1'b0},
    '{8'd200, 1'b1, 8'd0,   1'b0},
    // drain row: emits border row 2, frame end on the last byte
    '{8'd255, 1'b1, 8'd0,   1'b0}, '{8'd255, 1'b1, 8'd0, 1'b0},
    '{8'd255, 1'b1, 8'd0,   1'b1},
    // frame B, row 0
    '{8'd0,   1'b0, 8'd0,   1'b0}, '{8'd255, 1'b0, 8'd0, 1'b0},
    '{8'd0,   1'b0, 8'd0,   1'b0},
    // row 1
    '{8'd255, 1'b1, 8'd0,   1'b0}, '{8'd3,   1'b1, 8'd0, 1'b0},
    '{8'd255, 1'b1, 8'd0,   1'b0},
    // row 2: centre 15 - 4*255 clips to 0
    '{8'd0,   1'b1, 8'd0,   1'b0}, '{8'd255, 1'b1, 8'd0, 1'b0},
    '{8'd0,   1'b1, 8'd0,   1'b0},
    // drain row with junk bytes
    '{8'd1,   1'b1, 8'd0,   1'b0}, '{8'd128, 1'b1, 8'd0, 1'b0},
    '{8'd254, 1'b1, 8'd0,   1'b1}
  };

  sharpen_3x3_cross_stream_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sharpened_o (sharpened_o),
    .frame_end_o (frame_end_o)
  );

  // 100 MHz
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_bytes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned clamp_to(int unsigned x, int unsigned lo,
                                           int unsigned hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // effective channels, pixels and bytes per row after clamping
  function automatic void row_geometry(output int unsigned ch, output int unsigned cols,
                                       output int unsigned len);
    ch   = clamp_to(cfg_chans, 1, 4);
    cols = clamp_to(cfg_cols, 3, 2048);
    if (cols * ch > LINE_BYTES) cols = LINE_BYTES / ch;
    len  = cols * ch;
  endfunction

  // one accepted byte: advance the line stores and work out its result
  function automatic void sharpen_predict(input logic [7:0] s, output bit emits,
                                          output sharp_result_t res);
    int unsigned ch, cols, len, rows, col, idx, out_row;
    int          mid, left, right, up, acc;
    bit          drain, last;
    row_geometry(ch, cols, len);
    rows    = clamp_to(cfg_rows, 3, 4096);
    idx     = pos_byte % LINE_BYTES;
    col     = pos_byte / ch;
    drain   = pos_row >= rows;
    emits   = pos_row >= 1;
    res     = '0;
    out_row = pos_row - 1;
    // interior pixels only; border rows and columns stay zero
    if (emits && out_row != 0 && out_row < rows - 1 && col != 0 && col < cols - 1) begin
      if (line_sel) begin
        mid = line_b[idx]; left = line_b[idx - ch]; right = line_b[idx + ch];
        up  = line_a[idx];
      end else begin
        mid = line_a[idx]; left = line_a[idx - ch]; right = line_a[idx + ch];
        up  = line_b[idx];
      end
      acc = 5 * mid - left - right - up - int'(s);
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      res.sharpened = 8'(acc);
    end
    // incoming byte overwrites the row two above; drain bytes are dropped
    if (!drain) begin
      if (line_sel) line_a[idx] = s;
      else line_b[idx] = s;
    end
    last = pos_byte + 1 >= len;
    res.frame_end = emits && drain && last;
    if (last) begin
      pos_byte = 0;
      line_sel = !line_sel;
      pos_row  = drain ? 0 : ((pos_row + 1) & 13'h1FFF);
    end else begin
      pos_byte = (pos_byte + 1) & 13'h1FFF;
    end
  endfunction

  // offer one byte with random gaps, return once it is taken
  task automatic send_sample(input logic [7:0] s);
    bit may_idle;
    may_idle = items_sent < 250 || items_sent >= 450;
    while (may_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // whole frames plus drain row of random bytes, biased toward the rails
  task automatic send_frames(input int n_frames, inout int count);
    int unsigned ch, cols, len, rows;
    logic [7:0]  s;
    bit          emits;
    sharp_result_t res;
    row_geometry(ch, cols, len);
    rows = clamp_to(cfg_rows, 3, 4096);
    repeat (n_frames) begin
      for (int unsigned k = 0; k < (rows + 1) * len; k++) begin
        if ($urandom_range(3) == 0) s = $urandom_range(1) ? 8'hFF : 8'h00;
        else s = 8'($urandom);
        send_sample(s);
        sharpen_predict(s, emits, res);
        if (emits) pending_bytes.push_back(res);
        count++;
      end
      frames_sent++;
    end
  endtask

  // stop offering, let every result and the pipeline tail drain out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [3:0] addr, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== want) begin
      $error("register 0x%0h: expected %0d, actual %0d", addr, want, got);
      failures++;
    end
  endtask

  // program all three registers, read each back, mirror into the model
  task automatic set_geometry(input logic [11:0] cols, input logic [12:0] rows,
                              input logic [2:0] ch);
    wait_drained();
    apb_write(REG_COLUMNS, 32'(cols));
    apb_read_check(REG_COLUMNS, 32'(cols));
    apb_write(REG_ROWS, 32'(rows));
    apb_read_check(REG_ROWS, 32'(rows));
    apb_write(REG_CHANNELS, 32'(ch));
    apb_read_check(REG_CHANNELS, 32'(ch));
    cfg_cols  = cols;
    cfg_rows  = rows;
    cfg_chans = ch;
    geometries++;
  endtask

  // result side: compare each taken byte with the oldest prediction,
  // random stalls, one long hold-off to back the unit up into its input
  initial begin : result_check
    sharp_result_t want;
    int            hold_left;
    bit            hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_bytes.size() == 0) begin
          $error("unexpected result: sharpened=%0d frame_end=%0b", sharpened_o,
                 frame_end_o);
          failures++;
        end else begin
          want = pending_bytes.pop_front();
          if (sharpened_o !== want.sharpened) begin
            $error("sharpened: expected %0d, actual %0d", want.sharpened, sharpened_o);
            failures++;
          end
          if (frame_end_o !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end_o);
            failures++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && results_seen >= 150 && in_valid_i) begin
        // sender keeps going while we hold, so the operand queue fills
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (results_seen >= 250 && results_seen < 450) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // stimulus and final verdict
  initial begin : stimulus
    bit            emits;
    sharp_result_t res;
    int            random_items;
    logic [11:0]   pick_cols;
    logic [12:0]   pick_rows;
    logic [2:0]    pick_ch;
    // field extremes: zero, sub-minimum and minimum sizes, channel counts zero and above four
    logic [11:0]   ext_cols [3];
    logic [12:0]   ext_rows [3];
    logic [2:0]    ext_ch   [3];
    ext_cols     = '{12'd0, 12'd2, 12'd3};
    ext_rows     = '{13'd1, 13'd0, 13'd2};
    ext_ch       = '{3'd0,  3'd5,  3'd7};
    random_items = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry 640 x 480 x 3
    apb_read_check(REG_COLUMNS, 32'd640);
    apb_read_check(REG_ROWS, 32'd480);
    apb_read_check(REG_CHANNELS, 32'd3);

    // directed: smallest legal frame, typed-in results
    set_geometry(12'd3, 13'd3, 3'd1);
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_sample(directed_rows[r].sample);
      sharpen_predict(directed_rows[r].sample, emits, res);
      if (directed_rows[r].emits)
        pending_bytes.push_back('{directed_rows[r].sharpened, directed_rows[r].frame_end});
    end
    frames_sent += 2;

    // random small frames, broken up by the three extreme geometries
    for (int x = 0; x < 3; x++) begin
      while (random_items < (x + 1) * RANDOM_ITEMS / 3) begin
        if ($urandom_range(4) == 0) begin
          // out of range values, clamped by the unit
          pick_cols = 12'($urandom_range(2));
          pick_rows = 13'($urandom_range(2));
          pick_ch   = $urandom_range(1) ? 3'd0 : 3'($urandom_range(7, 5));
        end else begin
          pick_cols = 12'($urandom_range(7, 3));
          pick_rows = 13'($urandom_range(6, 3));
          pick_ch   = 3'($urandom_range(4, 1));
        end
        set_geometry(pick_cols, pick_rows, pick_ch);
        send_frames($urandom_range(3, 1), random_items);
      end
      set_geometry(ext_cols[x], ext_rows[x], ext_ch[x]);
      send_frames(1, random_items);
    end

    wait_drained();
    $display("%0d frames in %0d geometries, %0d items sent, %0d results checked",
             frames_sent, geometries, items_sent, results_seen);
    $display("clamped sizes 0..2, channel counts 0 and 5..7, one long stall; %0d cycles",
             cycle_count);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sharpen_3x3_cross_stream_unit.f
+incdir+rtl
rtl/sharp3_pkg.sv
rtl/sharp3_cfg.sv
rtl/sharp3_front.sv
rtl/sharp3_fifo.sv
rtl/sharp3_back.sv
rtl/sharpen_3x3_cross_stream_unit.sv
tb/sv/sharpen_3x3_cross_stream_unit_tb.sv
